// File: hw/rtl/fvec_pkg.sv
// Shared types, codes and saturating fixed-point helpers for the cell update block.
package fvec_pkg;

  localparam int WordBits = 32;
  localparam int FracBits = 16;
  localparam int MagBits  = WordBits + 1;
  localparam int ProdBits = 2 * MagBits;
  localparam int ShBits   = ProdBits - FracBits;
  localparam int DivBits  = WordBits + FracBits;
  localparam int CntBits  = $clog2(DivBits);
  localparam int CfgBits  = 23;
  localparam int CfgIdxBits = 3;

  typedef logic signed [WordBits-1:0] word_t;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_X    = 2'd1;
  localparam logic [1:0] CMD_Y    = 2'd2;
  localparam logic [1:0] CMD_Z    = 2'd3;

  localparam logic [CfgIdxBits-1:0] REG_DT_DX     = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_DT_DY     = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_DT_DZ     = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_GAMMA_M1  = 3'd3;
  localparam logic [CfgIdxBits-1:0] REG_INV_GM1   = 3'd4;
  localparam logic [CfgIdxBits-1:0] REG_RHO_FLOOR = 3'd5;
  localparam logic [CfgIdxBits-1:0] REG_P_FLOOR   = 3'd6;

  localparam word_t WORD_MAX = {1'b0, {(WordBits-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WordBits-1){1'b0}}};

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic word_t sat_add(word_t a, word_t b);
    logic [WordBits:0] s;
    s = {a[WordBits-1], a} + {b[WordBits-1], b};
    if (s[WordBits] != s[WordBits-1]) return s[WordBits] ? WORD_MIN : WORD_MAX;
    return word_t'(s[WordBits-1:0]);
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic [WordBits:0] s;
    s = {a[WordBits-1], a} - {b[WordBits-1], b};
    if (s[WordBits] != s[WordBits-1]) return s[WordBits] ? WORD_MIN : WORD_MAX;
    return word_t'(s[WordBits-1:0]);
  endfunction

  // Clamp a magnitude to the word range and apply the sign.
  function automatic word_t sat_mag(logic neg, logic [ShBits-1:0] m);
    logic [ShBits-1:0] lim;
    logic [WordBits-1:0] r;
    lim = neg ? (ShBits'(1) << (WordBits-1)) : ShBits'(WORD_MAX);
    if (m > lim) m = lim;
    r = m[WordBits-1:0];
    return neg ? word_t'(-r) : word_t'(r);
  endfunction

  function automatic logic [MagBits-1:0] mag(word_t a);
    return a[WordBits-1] ? (~{1'b1, a} + MagBits'(1)) : {1'b0, a};
  endfunction

  // Halve, rounding toward zero.
  function automatic word_t half_tz(word_t x);
    word_t t;
    t = x + word_t'({{(WordBits-1){1'b0}}, x[WordBits-1]});
    return t >>> 1;
  endfunction

  function automatic word_t floor_w(word_t x, logic [16:0] f);
    word_t fw;
    fw = word_t'({{(WordBits-17){1'b0}}, f});
    return (x < fw) ? fw : x;
  endfunction

endpackage

// File: hw/rtl/fvec_if.sv
// Valid/ready channel interfaces for face items and cell results.
interface fvec_in_if import fvec_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] command;
  word_t      lo_mass;
  word_t      lo_mom_x;
  word_t      lo_mom_y;
  word_t      lo_mom_z;
  word_t      lo_energy;
  word_t      hi_mass;
  word_t      hi_mom_x;
  word_t      hi_mom_y;
  word_t      hi_mom_z;
  word_t      hi_energy;

  modport source (output valid, command, lo_mass, lo_mom_x, lo_mom_y, lo_mom_z, lo_energy,
                  hi_mass, hi_mom_x, hi_mom_y, hi_mom_z, hi_energy, input ready);
  modport sink   (input valid, command, lo_mass, lo_mom_x, lo_mom_y, lo_mom_z, lo_energy,
                  hi_mass, hi_mom_x, hi_mom_y, hi_mom_z, hi_energy, output ready);
endinterface

interface fvec_out_if import fvec_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t new_density;
  word_t new_vel_x;
  word_t new_vel_y;
  word_t new_vel_z;
  word_t new_pressure;

  modport source (output valid, new_density, new_vel_x, new_vel_y, new_vel_z, new_pressure,
                  input ready);
  modport sink   (input valid, new_density, new_vel_x, new_vel_y, new_vel_z, new_pressure,
                  output ready);
endinterface

// File: hw/rtl/fvec_mul.sv
// Shared saturating Q16.16 multiplier with a registered product.
module fvec_mul import fvec_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  word_t a_i,
  input  word_t b_i,
  output word_t p_o
);

  logic [ProdBits-1:0] prod;
  word_t p_d, p_q;

  always_comb begin
    prod = ProdBits'(mag(a_i)) * ProdBits'(mag(b_i));
    p_d  = sat_mag(a_i[WordBits-1] ^ b_i[WordBits-1], prod[ProdBits-1:FracBits]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// File: hw/rtl/fvec_div.sv
// Restoring divider, one quotient bit per cycle, Q16.16 quotient with saturation.
module fvec_div import fvec_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  word_t     n_i,
  input  word_t     d_i,
  output div_stat_t stat_o,
  output word_t     q_o
);

  logic               busy_q, done_q;
  logic [CntBits-1:0] cnt_q;
  logic [MagBits-1:0] rem_q, md_q;
  logic [DivBits-1:0] sh_q;
  logic               neg_q, zero_q;
  logic [MagBits:0]   trial;
  logic               ge;

  always_comb begin
    trial = {rem_q, sh_q[DivBits-1]};
    ge    = trial >= {1'b0, md_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntBits'(DivBits - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntBits'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      md_q   <= mag(d_i);
      sh_q   <= DivBits'(mag(n_i)) << FracBits;
      neg_q  <= n_i[WordBits-1] ^ d_i[WordBits-1];
      zero_q <= (d_i == '0);
    end else if (busy_q) begin
      rem_q <= ge ? MagBits'(trial - {1'b0, md_q}) : trial[MagBits-1:0];
      sh_q  <= {sh_q[DivBits-2:0], ge};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign q_o    = zero_q ? '0 : sat_mag(neg_q, ShBits'(sh_q));

endmodule

// File: hw/rtl/finite_volume_euler_cell_update_unit.sv
// A load item runs the load and kinetic steps; an x or y face item runs the face steps only.
// The z item runs the face steps, three divisions on the shared divider, then the kinetic term
// and pressure on the shared multiplier; one item is in work at a time.
// A beat is taken only in the idle state, so a whole cell of four beats (load, x, y, z) goes
// in one beat at a time; the pressure step waits while the output register is full.
// Results sit in an output register, so the block takes the next beat while one waits.
// Reset (async, active low) clears accumulators, control state and sets config defaults.
module finite_volume_euler_cell_update_unit import fvec_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [CfgBits-1:0]    cfg_data_i,
  fvec_in_if.sink               in_i,
  fvec_out_if.source            out_o
);

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_FACE   = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DWAIT  = 3'd4;
  localparam logic [2:0] S_KIN    = 3'd5;
  localparam logic [2:0] S_PRES   = 3'd6;

  // Configuration registers
  logic [16:0] dtx_q, dty_q, dtz_q, rho_fl_q, p_fl_q;
  logic [17:0] gm1_q;
  logic [22:0] igm1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dtx_q    <= 17'd0;
      dty_q    <= 17'd0;
      dtz_q    <= 17'd0;
      gm1_q    <= 18'd43691;
      igm1_q   <= 23'd98304;
      rho_fl_q <= 17'd1;
      p_fl_q   <= 17'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DT_DX:     dtx_q    <= cfg_data_i[16:0];
        REG_DT_DY:     dty_q    <= cfg_data_i[16:0];
        REG_DT_DZ:     dtz_q    <= cfg_data_i[16:0];
        REG_GAMMA_M1:  gm1_q    <= cfg_data_i[17:0];
        REG_INV_GM1:   igm1_q   <= cfg_data_i[22:0];
        REG_RHO_FLOOR: rho_fl_q <= cfg_data_i[16:0];
        REG_P_FLOOR:   p_fl_q   <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  logic [2:0] state_q;
  logic [2:0] step_q;
  logic [1:0] cmd_q;
  word_t      acc_q [5];
  word_t      lo_q  [5];
  word_t      hi_q  [5];
  word_t      v_q   [3];
  word_t      rho_q, p_q, sq_q, tmp_q;
  logic       out_valid_q;
  word_t      out_q [5];

  logic       in_fire;
  logic       pres_fire;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  // Pressure step hands its beat over once the output register is free
  assign pres_fire  = (state_q == S_PRES) && (!out_valid_q || out_o.ready);

  // Shared multiplier operands
  logic  mul_en;
  word_t mul_a, mul_b, mul_p;
  word_t face_k, kin;
  word_t div_q;
  logic  div_start;
  div_stat_t div_stat;

  always_comb begin
    case (cmd_q)
      CMD_X:   face_k = word_t'({15'b0, dtx_q});
      CMD_Y:   face_k = word_t'({15'b0, dty_q});
      default: face_k = word_t'({15'b0, dtz_q});
    endcase
  end

  assign kin       = half_tz(mul_p);
  assign div_start = (state_q == S_DSTART);

  always_comb begin
    mul_en = 1'b0;
    mul_a  = rho_q;
    mul_b  = v_q[0];
    case (state_q)
      S_LOAD: begin
        mul_en = (step_q != 3'd4);
        case (step_q)
          3'd0:    mul_b = v_q[0];
          3'd1:    mul_b = v_q[1];
          3'd2:    mul_b = v_q[2];
          default: begin
            mul_a = p_q;
            mul_b = word_t'({9'b0, igm1_q});
          end
        endcase
      end
      S_FACE: begin
        mul_en = (step_q != 3'd5);
        mul_a  = face_k;
        mul_b  = (step_q < 3'd5) ? sat_sub(lo_q[step_q], hi_q[step_q]) : '0;
      end
      S_KIN: begin
        case (step_q)
          3'd0: begin
            mul_en = 1'b1; mul_a = v_q[0]; mul_b = v_q[0];
          end
          3'd1: begin
            mul_en = 1'b1; mul_a = v_q[1]; mul_b = v_q[1];
          end
          3'd2: begin
            mul_en = 1'b1; mul_a = v_q[2]; mul_b = v_q[2];
          end
          3'd4: begin
            mul_en = 1'b1; mul_a = rho_q; mul_b = sq_q;
          end
          3'd5: begin
            // Pressure product for the finish pass; the load pass ignores it
            mul_en = (cmd_q != CMD_LOAD);
            mul_a  = word_t'({14'b0, gm1_q});
            mul_b  = sat_sub(acc_q[4], kin);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  fvec_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  fvec_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (acc_q[step_q + 3'd1]),
    .d_i     (rho_q),
    .stat_o  (div_stat),
    .q_o     (div_q)
  );

  // Control and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      cmd_q       <= CMD_LOAD;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 5; i++) acc_q[i] <= '0;
    end else begin
      if (pres_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cmd_q   <= in_i.command;
            step_q  <= '0;
            state_q <= (in_i.command == CMD_LOAD) ? S_LOAD : S_FACE;
          end
        end
        S_LOAD: begin
          case (step_q)
            3'd1: acc_q[1] <= mul_p;
            3'd2: acc_q[2] <= mul_p;
            3'd3: begin
              acc_q[3] <= mul_p;
              acc_q[0] <= rho_q;
            end
            default: ;
          endcase
          if (step_q == 3'd4) begin
            step_q  <= '0;
            state_q <= S_KIN;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        S_FACE: begin
          if (step_q != 3'd0) acc_q[step_q - 3'd1] <= sat_add(acc_q[step_q - 3'd1], mul_p);
          if (step_q == 3'd5) begin
            step_q  <= '0;
            state_q <= (cmd_q == CMD_Z) ? S_DSTART : S_IDLE;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        S_DSTART: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (div_stat.done) begin
            if (step_q == 3'd2) begin
              step_q  <= '0;
              state_q <= S_KIN;
            end else begin
              step_q  <= step_q + 3'd1;
              state_q <= S_DSTART;
            end
          end
        end
        S_KIN: begin
          step_q <= step_q + 3'd1;
          if (step_q == 3'd5) begin
            if (cmd_q == CMD_LOAD) begin
              acc_q[4] <= sat_add(tmp_q, kin);
              state_q  <= S_IDLE;
            end else begin
              state_q <= S_PRES;
            end
          end
        end
        S_PRES: begin
          // Hold until the output register is free
          if (pres_fire) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      lo_q[0] <= in_i.lo_mass;
      lo_q[1] <= in_i.lo_mom_x;
      lo_q[2] <= in_i.lo_mom_y;
      lo_q[3] <= in_i.lo_mom_z;
      lo_q[4] <= in_i.lo_energy;
      hi_q[0] <= in_i.hi_mass;
      hi_q[1] <= in_i.hi_mom_x;
      hi_q[2] <= in_i.hi_mom_y;
      hi_q[3] <= in_i.hi_mom_z;
      hi_q[4] <= in_i.hi_energy;
      // Every beat taken: floor density and pressure, keep velocities for the load pass
      rho_q   <= floor_w(in_i.lo_mass, rho_fl_q);
      p_q     <= floor_w(in_i.lo_energy, p_fl_q);
      v_q[0]  <= in_i.lo_mom_x;
      v_q[1]  <= in_i.lo_mom_y;
      v_q[2]  <= in_i.lo_mom_z;
    end
    if (state_q == S_LOAD && step_q == 3'd4) tmp_q <= mul_p;
    if (state_q == S_FACE && step_q == 3'd5) rho_q <= floor_w(acc_q[0], rho_fl_q);
    if (state_q == S_DWAIT && div_stat.done) v_q[step_q[1:0]] <= div_q;
    if (state_q == S_KIN) begin
      case (step_q)
        3'd1: sq_q <= mul_p;
        3'd2: sq_q <= sat_add(sq_q, mul_p);
        3'd3: sq_q <= sat_add(sq_q, mul_p);
        default: ;
      endcase
    end
    if (pres_fire) begin
      out_q[0] <= rho_q;
      out_q[1] <= v_q[0];
      out_q[2] <= v_q[1];
      out_q[3] <= v_q[2];
      out_q[4] <= floor_w(mul_p, p_fl_q);
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.new_density  = out_q[0];
  assign out_o.new_vel_x    = out_q[1];
  assign out_o.new_vel_y    = out_q[2];
  assign out_o.new_vel_z    = out_q[3];
  assign out_o.new_pressure = out_q[4];

  // A new result beat only comes out of the pressure step
  a_out_from_pres: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_PRES)
    else $error("result raised outside pressure step");

  // The divider is never restarted while it works
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // Density and energy accumulators hold while idle with no beat taken
  a_acc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> $stable(acc_q[0]) && $stable(acc_q[4]))
    else $error("accumulator changed while idle");

  // Divider completion only seen while waiting for it
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == S_DWAIT)
    else $error("divider done outside wait state");

endmodule

// File: tb/finite_volume_euler_cell_update_unit_test.sv
// Self-checking testbench for the Euler cell update block: directed table, then random cells.
module finite_volume_euler_cell_update_unit_test;
  import fvec_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One face or load beat, and one finished cell.
  typedef struct {
    logic [1:0] cmd;
    word_t      lo[5];
    word_t      hi[5];
  } face_beat_t;

  typedef struct {
    word_t rho;
    word_t vx;
    word_t vy;
    word_t vz;
    word_t p;
  } cell_state_t;

  // Directed row: a beat plus, where it is obvious, the cell it must produce.
  typedef struct {
    face_beat_t  beat;
    bit          typed;
    cell_state_t want;
  } dir_row_t;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam word_t  ONE  = 32'sd65536;
  localparam int     DIR_SPLIT = 3;   // rows before this run with reset settings
  localparam int     DIR_ROWS  = 16;
  localparam int     SETTLE    = 220; // longer than the slowest beat in work

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxBits-1:0] cfg_idx_i;
  logic [CfgBits-1:0]    cfg_data_i;

  fvec_in_if  in_if ();
  fvec_out_if out_if ();

  finite_volume_euler_cell_update_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Shadow copies of the registers and accumulators.
  longint unsigned reg_shadow[7];
  longint          acc[5];
  cell_state_t     cells_due[$];
  int              error_cnt;
  int              tx_idle_pct;
  int              rx_idle_pct;
  int              hold_req;
  int              hold_seen;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #40ms;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------
  function automatic longint clampw(longint a);
    return (a > WMAX) ? WMAX : ((a < WMIN) ? WMIN : a);
  endfunction

  function automatic longint signed_sat(bit neg, longint unsigned m);
    longint unsigned lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (m > lim) m = lim;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned abs64(longint a);
    return (a < 0) ? longint'(-a) : a;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return signed_sat((a < 0) != (b < 0), (abs64(a) * abs64(b)) >> FracBits);
  endfunction

  function automatic longint qdiv(longint n, longint d);
    if (d == 0) return 0;
    return signed_sat((n < 0) != (d < 0), (abs64(n) << FracBits) / abs64(d));
  endfunction

  function automatic longint kinetic_energy(longint rho, longint vx, longint vy, longint vz);
    longint sq;
    sq = clampw(clampw(qmul(vx, vx) + qmul(vy, vy)) + qmul(vz, vz));
    return qmul(rho, sq) / 2;  // truncates toward zero
  endfunction

  // Advance the shadow cell by one beat; report the finished cell on a z beat.
  function automatic bit advance_cell(face_beat_t b, output cell_state_t r);
    longint rho, p, k, vx, vy, vz;
    longint v[5];
    r = '{default: '0};
    if (b.cmd == CMD_LOAD) begin
      rho = b.lo[0];
      if (rho < longint'(reg_shadow[REG_RHO_FLOOR])) rho = reg_shadow[REG_RHO_FLOOR];
      p = b.lo[4];
      if (p < longint'(reg_shadow[REG_P_FLOOR])) p = reg_shadow[REG_P_FLOOR];
      for (int i = 0; i < 5; i++) v[i] = b.lo[i];
      acc[0] = rho;
      acc[1] = qmul(rho, v[1]);
      acc[2] = qmul(rho, v[2]);
      acc[3] = qmul(rho, v[3]);
      acc[4] = clampw(qmul(p, reg_shadow[REG_INV_GM1]) + kinetic_energy(rho, v[1], v[2], v[3]));
      return 1'b0;
    end
    k = reg_shadow[REG_DT_DX + b.cmd - 1];
    for (int i = 0; i < 5; i++)
      acc[i] = clampw(acc[i] + qmul(k, clampw(longint'(b.lo[i]) - longint'(b.hi[i]))));
    if (b.cmd != CMD_Z) return 1'b0;
    rho = acc[0];
    if (rho < longint'(reg_shadow[REG_RHO_FLOOR])) rho = reg_shadow[REG_RHO_FLOOR];
    vx = qdiv(acc[1], rho);
    vy = qdiv(acc[2], rho);
    vz = qdiv(acc[3], rho);
    p = qmul(reg_shadow[REG_GAMMA_M1], clampw(acc[4] - kinetic_energy(rho, vx, vy, vz)));
    if (p < longint'(reg_shadow[REG_P_FLOOR])) p = reg_shadow[REG_P_FLOOR];
    r.rho = word_t'(rho);
    r.vx  = word_t'(vx);
    r.vy  = word_t'(vy);
    r.vz  = word_t'(vz);
    r.p   = word_t'(p);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration and beat driving
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [CfgIdxBits-1:0] idx, int unsigned val);
    int w;
    w = (idx == REG_GAMMA_M1) ? 18 : ((idx == REG_INV_GM1) ? 23 : 17);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CfgBits'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    reg_shadow[idx] = val & ((64'd1 << w) - 1);
  endtask

  task automatic apply_settings(int unsigned dx, int unsigned dy, int unsigned dz,
                                int unsigned gm1, int unsigned igm1,
                                int unsigned rfl, int unsigned pfl);
    write_reg(REG_DT_DX, dx);
    write_reg(REG_DT_DY, dy);
    write_reg(REG_DT_DZ, dz);
    write_reg(REG_GAMMA_M1, gm1);
    write_reg(REG_INV_GM1, igm1);
    write_reg(REG_RHO_FLOOR, rfl);
    write_reg(REG_P_FLOOR, pfl);
  endtask

  // Drop valid and hold until every finished cell is out and the block has settled.
  task automatic drain_block();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Offer one beat, wait for the handshake, then advance the predictor.
  task automatic send_beat(face_beat_t b, bit typed, cell_state_t want);
    int gap;
    cell_state_t got;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.command   <= b.cmd;
    in_if.lo_mass   <= b.lo[0];
    in_if.lo_mom_x  <= b.lo[1];
    in_if.lo_mom_y  <= b.lo[2];
    in_if.lo_mom_z  <= b.lo[3];
    in_if.lo_energy <= b.lo[4];
    in_if.hi_mass   <= b.hi[0];
    in_if.hi_mom_x  <= b.hi[1];
    in_if.hi_mom_y  <= b.hi[2];
    in_if.hi_mom_z  <= b.hi[3];
    in_if.hi_energy <= b.hi[4];
    do @(posedge clk_i); while (!in_if.ready);
    if (advance_cell(b, got)) cells_due.push_back(typed ? want : got);
  endtask

  // Mostly moderate Q16.16 values, with full-range, extreme and zero words mixed in.
  function automatic word_t pick_word(bit positive);
    int unsigned r;
    r = $urandom_range(19);
    if (r < 11) return positive ? word_t'($urandom_range(32'h60000, 1))
                                : word_t'(int'($urandom_range(32'h80000)) - 32'h40000);
    if (r < 15) return word_t'($urandom);
    if (r == 15) return WORD_MAX;
    if (r == 16) return WORD_MIN;
    if (r == 17) return '0;
    return ONE;
  endfunction

  function automatic face_beat_t make_beat(logic [1:0] cmd);
    face_beat_t b;
    b.cmd = cmd;
    for (int i = 0; i < 5; i++) begin
      b.lo[i] = pick_word(cmd == CMD_LOAD && (i == 0 || i == 4));
      b.hi[i] = pick_word(1'b0);
    end
    return b;
  endfunction

  // Random settings within the register ranges; skew dt small so flux sums stay readable.
  task automatic random_settings();
    apply_settings($urandom_range(65536), $urandom_range(8192), $urandom_range(65536),
                   $urandom_range(131072), $urandom_range(4194304),
                   $urandom_range(65536), $urandom_range(65536));
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  localparam cell_state_t FLOORED_ZERO = '{rho: 32'sd1, vx: '0, vy: '0, vz: '0, p: 32'sd1};
  localparam cell_state_t NONE = '{default: '0};

  dir_row_t dir_rows[DIR_ROWS] = '{
    // Reset settings: every dt is zero, so fluxes vanish and the empty cell floors to one LSB.
    '{'{CMD_Z, '{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX},
              '{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN}}, 1'b1, FLOORED_ZERO},
    '{'{CMD_X, '{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN},
              '{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX}}, 1'b0, NONE},
    '{'{CMD_Z, '{'0, '0, '0, '0, '0}, '{'0, '0, '0, '0, '0}}, 1'b1, FLOORED_ZERO},
    // Typical cell, then saturating loads and fluxes.
    '{'{CMD_LOAD, '{32'sd131072, ONE, -ONE, 32'sd32768, ONE},
                 '{WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX}}, 1'b0, NONE},
    '{'{CMD_X, '{32'sd4096, 32'sd8192, -32'sd8192, 32'sd100, 32'sd65536},
              '{32'sd2048, -32'sd8192, 32'sd8192, -32'sd100, 32'sd0}}, 1'b0, NONE},
    '{'{CMD_Y, '{-32'sd4096, 32'sd1, 32'sd2, 32'sd3, -ONE},
              '{32'sd4096, -32'sd1, -32'sd2, -32'sd3, ONE}}, 1'b0, NONE},
    '{'{CMD_Z, '{32'sd700, 32'sd70, -32'sd7, 32'sd0, 32'sd7000},
              '{-32'sd700, 32'sd0, 32'sd7, 32'sd9, 32'sd0}}, 1'b0, NONE},
    '{'{CMD_LOAD, '{WORD_MIN, WORD_MAX, WORD_MIN, '0, WORD_MIN},
                 '{'0, '0, '0, '0, '0}}, 1'b0, NONE},
    '{'{CMD_Z, '{'0, '0, '0, '0, '0}, '{'0, '0, '0, '0, '0}}, 1'b0, NONE},
    '{'{CMD_Z, '{'0, '0, '0, '0, '0}, '{'0, '0, '0, '0, '0}}, 1'b0, NONE},
    '{'{CMD_LOAD, '{WORD_MAX, '0, '0, '0, WORD_MAX}, '{'0, '0, '0, '0, '0}}, 1'b0, NONE},
    '{'{CMD_X, '{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX},
              '{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN}}, 1'b0, NONE},
    '{'{CMD_Y, '{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN},
              '{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX}}, 1'b0, NONE},
    '{'{CMD_Z, '{WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX},
              '{WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN}}, 1'b0, NONE},
    '{'{CMD_LOAD, '{32'sd1, WORD_MAX, WORD_MIN, 32'sd12345678, 32'sd1},
                 '{'0, '0, '0, '0, '0}}, 1'b0, NONE},
    '{'{CMD_Z, '{'0, '0, '0, '0, '0}, '{'0, '0, '0, '0, '0}}, 1'b0, NONE}
  };

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when the stimulus asks for one
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 2000;  // long enough for several z beats to back up the input
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Check every finished cell against the oldest one predicted.
  always @(posedge clk_i) begin
    cell_state_t e;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (cells_due.size() == 0) begin
        $display("%0t: unexpected cell rho=%h vx=%h vy=%h vz=%h p=%h", $time,
                 out_if.new_density, out_if.new_vel_x, out_if.new_vel_y,
                 out_if.new_vel_z, out_if.new_pressure);
        error_cnt++;
      end else begin
        e = cells_due.pop_front();
        if (out_if.new_density !== e.rho) begin
          $display("%0t: density expected %h got %h", $time, e.rho, out_if.new_density);
          error_cnt++;
        end
        if (out_if.new_vel_x !== e.vx) begin
          $display("%0t: vel_x expected %h got %h", $time, e.vx, out_if.new_vel_x);
          error_cnt++;
        end
        if (out_if.new_vel_y !== e.vy) begin
          $display("%0t: vel_y expected %h got %h", $time, e.vy, out_if.new_vel_y);
          error_cnt++;
        end
        if (out_if.new_vel_z !== e.vz) begin
          $display("%0t: vel_z expected %h got %h", $time, e.vz, out_if.new_vel_z);
          error_cnt++;
        end
        if (out_if.new_pressure !== e.p) begin
          $display("%0t: pressure expected %h got %h", $time, e.p, out_if.new_pressure);
          error_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    face_beat_t b;
    logic [1:0] cmd;
    int sent;
    error_cnt   = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    in_if.valid = 1'b0;
    in_if.command = CMD_LOAD;
    {in_if.lo_mass, in_if.lo_mom_x, in_if.lo_mom_y, in_if.lo_mom_z, in_if.lo_energy} = '0;
    {in_if.hi_mass, in_if.hi_mom_x, in_if.hi_mom_y, in_if.hi_mom_z, in_if.hi_energy} = '0;
    reg_shadow = '{0, 0, 0, 43691, 98304, 1, 1};
    acc = '{default: 0};
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows, first with reset settings, then with a plain setting.
    for (int i = 0; i < DIR_SPLIT; i++)
      send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    drain_block();
    apply_settings(65536, 32768, 1, 43691, 98304, 1, 1);
    for (int i = DIR_SPLIT; i < DIR_ROWS; i++)
      send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

    // Random phases: each applies its own setting and one of three idling patterns.
    for (int ph = 0; ph < 6; ph++) begin
      drain_block();
      case (ph)
        0: apply_settings(8192, 4096, 2048, 43691, 98304, 1, 1);
        1: apply_settings(65536, 65536, 65536, 131072, 4194304, 65536, 65536);
        2: apply_settings(0, 0, 0, 0, 0, 0, 0);   // floors off: zero density reachable
        default: random_settings();
      endcase
      case (ph % 3)
        0: begin
          tx_idle_pct = 35;
          rx_idle_pct = 76;
        end
        1: begin
          tx_idle_pct = 76;
          rx_idle_pct = 35;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < 275) begin
        // Mostly whole cells: load, x, y, z; otherwise a stray command.
        if ($urandom_range(9) < 8) begin
          for (int c = 0; c < 4; c++) begin
            cmd = 2'(c);
            b = make_beat(cmd);
            send_beat(b, 1'b0, NONE);
            sent++;
            if (ph == 0 && sent == 40) hold_req++;
          end
        end else begin
          cmd = 2'($urandom_range(3));
          b = make_beat(cmd);
          send_beat(b, 1'b0, NONE);
          sent++;
        end
      end
    end

    drain_block();
    if (error_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
